// ===== hdl/cp0_pkg.sv =====
// shared types and constants of the coprocessor-0 exception and interrupt unit
// command codes, register numbers and bit positions of status and cause
// no dependencies
`timescale 1ns / 1ps

package cp0_pkg;

    // command codes of an input item
    typedef enum logic [3:0] {
        CMD_READ      = 4'd0,
        CMD_WRITE     = 4'd1,
        CMD_IRQ_SET   = 4'd2,
        CMD_IRQ_CLEAR = 4'd3,
        CMD_TICK      = 4'd4,
        CMD_EXCEPTION = 4'd5,
        CMD_RETURN    = 4'd6,
        CMD_SET_IE    = 4'd7,
        CMD_SYSCALL   = 4'd8,
        CMD_WAIT      = 4'd9
    } cmd_t;

    // dense register numbers
    typedef enum logic [3:0] {
        SEL_COUNT    = 4'd0,
        SEL_COMPARE  = 4'd1,
        SEL_STATUS   = 4'd2,
        SEL_CAUSE    = 4'd3,
        SEL_EPC      = 4'd4,
        SEL_CONFIG   = 4'd5,
        SEL_SCCODE   = 4'd6,
        SEL_CPUID    = 4'd7,
        SEL_EBASE    = 4'd8,
        SEL_TAGLO    = 4'd9,
        SEL_TAGHI    = 4'd10,
        SEL_ERROREPC = 4'd11,
        SEL_L2REG    = 4'd12
    } sel_t;

    // configuration register indexes
    localparam logic CFG_CPU_NUMBER  = 1'b0;
    localparam logic CFG_CONFIG_WORD = 1'b1;

    // status bits
    localparam int ST_IE  = 0;
    localparam int ST_EXL = 1;
    localparam int ST_ERL = 2;
    localparam int ST_BEV = 22;

    // cause bits
    localparam int CA_BD     = 31;
    localparam int CA_IP_HW  = 10;
    localparam int CA_IP_TMR = 15;

    localparam logic [31:0] BOOT_VECTOR   = 32'hBFC0_0200;
    localparam logic [31:0] CAUSE_SW_MASK = 32'h0000_0300;
    localparam logic [31:0] STATUS_RESET  = 32'h0040_0000;
    localparam logic [4:0]  EXC_INTERRUPT = 5'd0;

endpackage

// ===== hdl/cp0_exception_interrupt_unit.sv =====
// coprocessor-0 exception and interrupt unit: registers, timer, interrupt test
// and exception entry and return, one item in and one result item out
// depends on cp0_pkg
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+------------------------
//   in      | in_valid in_ready command .. delay_slot   | one command per item
//   out     | out_valid out_ready read_data .. error    | one result per item
//   cfg     | cfg_write cfg_index cfg_data              | cpu number, config word
//
// Each item is decoded and applied to the register state in the cycle it is
// accepted; its result sits in the output register from the next cycle. One
// item per cycle is sustained while results are taken, set by the single
// output register stage. A stalled result holds in_ready low until taken.
// Reset clears the state to its reset values and the output valid flag.
`timescale 1ns / 1ps

module cp0_exception_interrupt_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [3:0]  reg_select,
    input  logic [31:0] write_data,
    input  logic [4:0]  exc_code,
    input  logic [31:0] current_instr_addr,
    input  logic [31:0] resume_pc,
    input  logic        delay_slot,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        redirect,
    output logic [31:0] target_pc,
    output logic        interrupt_taken,
    output logic        halted,
    output logic        error
);

    // architectural state
    logic        cpu_number_reg;
    logic [31:0] config_word_reg;
    logic [31:0] count_reg, count_next;
    logic [31:0] compare_reg, compare_next;
    logic [31:0] status_reg, status_next;
    logic [31:0] cause_reg, cause_next;
    logic [31:0] epc_reg, epc_next;
    logic [31:0] error_epc_reg, error_epc_next;
    logic [31:0] ebase_reg, ebase_next;
    logic [31:0] sccode_reg, sccode_next;
    logic [31:0] taglo_reg, taglo_next;
    logic [31:0] taghi_reg, taghi_next;
    logic        wait_reg, wait_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] read_data_reg, read_data_next;
    logic        redirect_reg, redirect_next;
    logic [31:0] target_reg, target_next;
    logic        irq_reg, irq_next;
    logic        error_reg, error_next;

    logic        accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // interrupt pending test on a status and cause pair
    function automatic logic irq_pending(input logic [31:0] st, input logic [31:0] ca);
        return st[cp0_pkg::ST_IE] && !st[cp0_pkg::ST_EXL] && !st[cp0_pkg::ST_ERL]
               && ((st[15:8] & ca[15:8]) != 8'd0);
    endfunction

    // command decode and state update
    always_comb
    begin
        logic        do_check;
        logic [31:0] chk_src;
        logic        chk_ds;
        logic        enter;
        logic [4:0]  enter_code;
        logic [31:0] enter_src;
        logic        enter_ds;
        logic [31:0] count_inc;

        count_next     = count_reg;
        compare_next   = compare_reg;
        status_next    = status_reg;
        cause_next     = cause_reg;
        epc_next       = epc_reg;
        error_epc_next = error_epc_reg;
        ebase_next     = ebase_reg;
        sccode_next    = sccode_reg;
        taglo_next     = taglo_reg;
        taghi_next     = taghi_reg;
        wait_next      = wait_reg;

        read_data_next = 32'd0;
        redirect_next  = 1'b0;
        target_next    = 32'd0;
        irq_next       = 1'b0;
        error_next     = 1'b0;

        do_check   = 1'b0;
        chk_src    = resume_pc;
        chk_ds     = delay_slot;
        enter      = 1'b0;
        enter_code = exc_code;
        enter_src  = current_instr_addr;
        enter_ds   = delay_slot;
        count_inc  = count_reg + 32'd1;

        case (cp0_pkg::cmd_t'(command))
            cp0_pkg::CMD_READ:
            begin
                unique case (cp0_pkg::sel_t'(reg_select))
                    cp0_pkg::SEL_COUNT:    read_data_next = count_reg;
                    cp0_pkg::SEL_COMPARE:  read_data_next = compare_reg;
                    cp0_pkg::SEL_STATUS:   read_data_next = status_reg;
                    cp0_pkg::SEL_CAUSE:    read_data_next = cause_reg;
                    cp0_pkg::SEL_EPC:      read_data_next = epc_reg;
                    cp0_pkg::SEL_CONFIG:   read_data_next = config_word_reg;
                    cp0_pkg::SEL_SCCODE:   read_data_next = sccode_reg;
                    cp0_pkg::SEL_CPUID:    read_data_next = {31'd0, cpu_number_reg};
                    cp0_pkg::SEL_EBASE:    read_data_next = ebase_reg;
                    cp0_pkg::SEL_TAGLO:    read_data_next = taglo_reg;
                    cp0_pkg::SEL_TAGHI:    read_data_next = taghi_reg;
                    cp0_pkg::SEL_ERROREPC: read_data_next = error_epc_reg;
                    cp0_pkg::SEL_L2REG:    read_data_next = 32'd0;
                    default:               error_next = 1'b1;
                endcase
            end
            cp0_pkg::CMD_WRITE:
            begin
                do_check = 1'b1;
                unique case (cp0_pkg::sel_t'(reg_select))
                    cp0_pkg::SEL_COUNT:    count_next = write_data;
                    cp0_pkg::SEL_COMPARE:
                    begin
                        compare_next = write_data;
                        cause_next[cp0_pkg::CA_IP_TMR] = 1'b0;
                    end
                    cp0_pkg::SEL_STATUS:   status_next = write_data;
                    cp0_pkg::SEL_CAUSE:
                        cause_next = (cause_reg & ~cp0_pkg::CAUSE_SW_MASK)
                                   | (write_data & cp0_pkg::CAUSE_SW_MASK);
                    cp0_pkg::SEL_EPC:      epc_next = write_data;
                    cp0_pkg::SEL_EBASE:    ebase_next = write_data;
                    cp0_pkg::SEL_TAGLO:    taglo_next = write_data;
                    cp0_pkg::SEL_TAGHI:    taghi_next = write_data;
                    cp0_pkg::SEL_ERROREPC: error_epc_next = write_data;
                    default:
                    begin
                        // read-only or unimplemented register
                        error_next = 1'b1;
                        do_check   = 1'b0;
                    end
                endcase
            end
            cp0_pkg::CMD_IRQ_SET:
            begin
                cause_next[cp0_pkg::CA_IP_HW] = 1'b1;
                do_check = 1'b1;
            end
            cp0_pkg::CMD_IRQ_CLEAR:
                cause_next[cp0_pkg::CA_IP_HW] = 1'b0;
            cp0_pkg::CMD_TICK:
            begin
                count_next = count_inc;
                if (count_inc == compare_reg)
                    cause_next[cp0_pkg::CA_IP_TMR] = 1'b1;
                do_check = 1'b1;
            end
            cp0_pkg::CMD_EXCEPTION:
            begin
                if (status_reg[cp0_pkg::ST_EXL])
                    error_next = 1'b1;
                else
                    enter = 1'b1;
            end
            cp0_pkg::CMD_RETURN:
            begin
                if (status_reg[cp0_pkg::ST_ERL] || !status_reg[cp0_pkg::ST_EXL])
                    error_next = 1'b1;
                else
                begin
                    status_next[cp0_pkg::ST_EXL] = 1'b0;
                    redirect_next = 1'b1;
                    target_next   = {epc_reg[31:2], 2'b00};
                    do_check      = 1'b1;
                    chk_src       = {epc_reg[31:2], 2'b00};
                    chk_ds        = 1'b0;
                end
            end
            cp0_pkg::CMD_SET_IE:
            begin
                status_next[cp0_pkg::ST_IE] = write_data[0];
                do_check = 1'b1;
            end
            cp0_pkg::CMD_SYSCALL:
                sccode_next = {write_data[29:0], 2'b00};
            cp0_pkg::CMD_WAIT:
            begin
                wait_next = 1'b1;
                status_next[cp0_pkg::ST_IE] = 1'b1;
                do_check = 1'b1;
            end
            default:
            begin
                // undefined command: no effect
            end
        endcase

        // interrupt test after the command's effect
        if (do_check && irq_pending(status_next, cause_next))
        begin
            enter      = 1'b1;
            enter_code = cp0_pkg::EXC_INTERRUPT;
            enter_src  = chk_src;
            enter_ds   = chk_ds;
            irq_next   = 1'b1;
            wait_next  = 1'b0;
        end

        // exception entry, vector from the base as updated by this item
        if (enter)
        begin
            cause_next[6:2] = enter_code;
            cause_next[cp0_pkg::CA_BD] = enter_ds;
            epc_next = enter_ds ? (enter_src - 32'd4) : enter_src;
            status_next[cp0_pkg::ST_EXL] = 1'b1;
            redirect_next = 1'b1;
            target_next = status_next[cp0_pkg::ST_BEV] ? cp0_pkg::BOOT_VECTOR
                                                       : {ebase_next[31:2], 2'b00};
        end
    end

    // state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_number_reg  <= 1'b0;
            config_word_reg <= 32'd0;
            count_reg       <= 32'd0;
            compare_reg     <= 32'd0;
            status_reg      <= cp0_pkg::STATUS_RESET;
            cause_reg       <= 32'd0;
            epc_reg         <= 32'd0;
            error_epc_reg   <= 32'd0;
            ebase_reg       <= 32'd0;
            sccode_reg      <= 32'd0;
            taglo_reg       <= 32'd0;
            taghi_reg       <= 32'd0;
            wait_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == cp0_pkg::CFG_CPU_NUMBER)
                    cpu_number_reg <= cfg_data[0];
                else
                    config_word_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                compare_reg   <= compare_next;
                status_reg    <= status_next;
                cause_reg     <= cause_next;
                epc_reg       <= epc_next;
                error_epc_reg <= error_epc_next;
                ebase_reg     <= ebase_next;
                sccode_reg    <= sccode_next;
                taglo_reg     <= taglo_next;
                taghi_reg     <= taghi_next;
                wait_reg      <= wait_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            redirect_reg  <= redirect_next;
            target_reg    <= target_next;
            irq_reg       <= irq_next;
            error_reg     <= error_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign redirect        = redirect_reg;
    assign target_pc       = target_reg;
    assign interrupt_taken = irq_reg;
    assign halted          = wait_reg;
    assign error           = error_reg;

endmodule

// ===== hdl/cp0_checker.sv =====
// port-level checks of the coprocessor-0 exception and interrupt unit
// bound to cp0_exception_interrupt_unit; no package dependency
`timescale 1ns / 1ps

module cp0_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        redirect,
    input logic [31:0] target_pc,
    input logic        interrupt_taken,
    input logic        halted
);

    // a stalled result keeps its redirect target
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target_pc) && $stable(redirect))
    else $error("stalled result changed");

    // an interrupt entry always redirects fetch
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && interrupt_taken |-> redirect && !halted)
    else $error("interrupt taken without redirect or while halted");

    // no target without a redirect, and targets are word aligned
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (redirect || target_pc == 32'd0) && target_pc[1:0] == 2'b00)
    else $error("bad target address");

    // a new item is taken whenever the result slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind cp0_exception_interrupt_unit cp0_checker u_cp0_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .redirect        (redirect),
    .target_pc       (target_pc),
    .interrupt_taken (interrupt_taken),
    .halted          (halted)
);

// ===== sim/cp0_result_checker.sv =====
// result checker for the coprocessor-0 exception and interrupt unit
// watches the config port and both item channels, predicts every result and compares it
// depends on cp0_pkg
`timescale 1ns / 1ps

module cp0_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  command,
    input  logic [3:0]  reg_select,
    input  logic [31:0] write_data,
    input  logic [4:0]  exc_code,
    input  logic [31:0] current_instr_addr,
    input  logic [31:0] resume_pc,
    input  logic        delay_slot,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] read_data,
    input  logic        redirect,
    input  logic [31:0] target_pc,
    input  logic        interrupt_taken,
    input  logic        halted,
    input  logic        error,
    output int          fail_count,
    output int          outstanding
);
    import cp0_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int IM_HI = 15;
    localparam int IM_LO = 8;

    typedef struct packed {
        logic [31:0] read_data;
        logic        redirect;
        logic [31:0] target_pc;
        logic        interrupt_taken;
        logic        halted;
        logic        error;
    } cp0_result_t;

    // shadow copy of the register state
    logic [31:0] count_q;
    logic [31:0] compare_q;
    logic [31:0] status_q;
    logic [31:0] cause_q;
    logic [31:0] epc_q;
    logic [31:0] error_epc_q;
    logic [31:0] ebase_q;
    logic [31:0] sccode_q;
    logic [31:0] tag_lo_q;
    logic [31:0] tag_hi_q;
    logic        waiting_q;
    logic        cpu_id_q;
    logic [31:0] config_q;

    cp0_result_t expected_q[$];

    // enabled, not at exception level, and some masked line raised
    function automatic logic irq_pending();
        return status_q[ST_IE] && !status_q[ST_EXL] && !status_q[ST_ERL] &&
               ((status_q[IM_HI:IM_LO] & cause_q[IM_HI:IM_LO]) != 8'h00);
    endfunction

    // record code, delay-slot bit and epc, raise exl, redirect to the vector
    function automatic void take_exception(input logic [4:0] code, input logic [31:0] src,
                                           input logic in_slot, inout cp0_result_t res);
        cause_q[6:2] = code;
        cause_q[CA_BD] = in_slot;
        epc_q = in_slot ? src - 32'd4 : src;
        status_q[ST_EXL] = 1'b1;
        res.redirect = 1'b1;
        res.target_pc = (status_q[ST_BEV] ? BOOT_VECTOR : ebase_q) & ~32'd3;
    endfunction

    function automatic void test_interrupt(input logic [31:0] src, input logic in_slot,
                                           inout cp0_result_t res);
        if (irq_pending())
        begin
            take_exception(EXC_INTERRUPT, src, in_slot, res);
            res.interrupt_taken = 1'b1;
            waiting_q = 1'b0;
        end
    endfunction

    function automatic logic [31:0] register_value(input logic [3:0] sel);
        case (sel)
            SEL_COUNT:    return count_q;
            SEL_COMPARE:  return compare_q;
            SEL_STATUS:   return status_q;
            SEL_CAUSE:    return cause_q;
            SEL_EPC:      return epc_q;
            SEL_CONFIG:   return config_q;
            SEL_SCCODE:   return sccode_q;
            SEL_CPUID:    return {31'd0, cpu_id_q};
            SEL_EBASE:    return ebase_q;
            SEL_TAGLO:    return tag_lo_q;
            SEL_TAGHI:    return tag_hi_q;
            SEL_ERROREPC: return error_epc_q;
            default:      return 32'd0;
        endcase
    endfunction

    // returns 0 for registers that cannot be written
    function automatic logic write_register(input logic [3:0] sel, input logic [31:0] value);
        case (sel)
            SEL_COUNT:    count_q = value;
            SEL_COMPARE:
            begin
                compare_q = value;
                cause_q[CA_IP_TMR] = 1'b0;
            end
            SEL_STATUS:   status_q = value;
            SEL_CAUSE:    cause_q = (cause_q & ~CAUSE_SW_MASK) | (value & CAUSE_SW_MASK);
            SEL_EPC:      epc_q = value;
            SEL_EBASE:    ebase_q = value;
            SEL_TAGLO:    tag_lo_q = value;
            SEL_TAGHI:    tag_hi_q = value;
            SEL_ERROREPC: error_epc_q = value;
            default:      return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // applies one command item to the shadow state and returns its result item
    function automatic cp0_result_t predict_cp0(input logic [3:0] cmd, input logic [3:0] sel,
                                                input logic [31:0] wd, input logic [4:0] code,
                                                input logic [31:0] iaddr, input logic [31:0] rpc,
                                                input logic ds);
        cp0_result_t res;
        logic [31:0] back_pc;
        res = '0;
        case (cmd)
            CMD_READ:
            begin
                res.read_data = register_value(sel);
                res.error = (sel > SEL_L2REG);
            end
            CMD_WRITE:
            begin
                if (write_register(sel, wd))
                    test_interrupt(rpc, ds, res);
                else
                    res.error = 1'b1;
            end
            CMD_IRQ_SET:
            begin
                cause_q[CA_IP_HW] = 1'b1;
                test_interrupt(rpc, ds, res);
            end
            CMD_IRQ_CLEAR: cause_q[CA_IP_HW] = 1'b0;
            CMD_TICK:
            begin
                count_q = count_q + 32'd1;
                if (count_q == compare_q)
                    cause_q[CA_IP_TMR] = 1'b1;
                test_interrupt(rpc, ds, res);
            end
            CMD_EXCEPTION:
            begin
                if (status_q[ST_EXL])
                    res.error = 1'b1;
                else
                    take_exception(code, iaddr, ds, res);
            end
            CMD_RETURN:
            begin
                if (status_q[ST_ERL] || !status_q[ST_EXL])
                begin
                    res.error = 1'b1;
                end
                else
                begin
                    status_q[ST_EXL] = 1'b0;
                    back_pc = epc_q & ~32'd3;
                    res.redirect = 1'b1;
                    res.target_pc = back_pc;
                    test_interrupt(back_pc, 1'b0, res);
                end
            end
            CMD_SET_IE:
            begin
                status_q[ST_IE] = wd[0];
                test_interrupt(rpc, ds, res);
            end
            CMD_SYSCALL:   sccode_q = wd << 2;
            CMD_WAIT:
            begin
                waiting_q = 1'b1;
                status_q[ST_IE] = 1'b1;
                test_interrupt(rpc, ds, res);
            end
            default: ;
        endcase
        res.halted = waiting_q;
        return res;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (fail_count < MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        fail_count++;
    endtask

    // config writes, then the result side, then the command side of each edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        cp0_result_t want;
        if (!rst_n)
        begin
            count_q     = '0;
            compare_q   = '0;
            status_q    = STATUS_RESET;
            cause_q     = '0;
            epc_q       = '0;
            error_epc_q = '0;
            ebase_q     = '0;
            sccode_q    = '0;
            tag_lo_q    = '0;
            tag_hi_q    = '0;
            waiting_q   = 1'b0;
            cpu_id_q    = 1'b0;
            config_q    = '0;
            expected_q.delete();
            fail_count  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_CPU_NUMBER)
                    cpu_id_q = cfg_data[0];
                else
                    config_q = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    note_failure("result item with none expected, read_data", 32'd0, read_data);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (read_data !== want.read_data)
                        note_failure("read_data", want.read_data, read_data);
                    if (redirect !== want.redirect)
                        note_failure("redirect", 32'(want.redirect), 32'(redirect));
                    if (target_pc !== want.target_pc)
                        note_failure("target_pc", want.target_pc, target_pc);
                    if (interrupt_taken !== want.interrupt_taken)
                        note_failure("interrupt_taken", 32'(want.interrupt_taken),
                                     32'(interrupt_taken));
                    if (halted !== want.halted)
                        note_failure("halted", 32'(want.halted), 32'(halted));
                    if (error !== want.error)
                        note_failure("error", 32'(want.error), 32'(error));
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_cp0(command, reg_select, write_data, exc_code,
                                                 current_instr_addr, resume_pc, delay_slot));
        end
        outstanding = expected_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
// top of the coprocessor-0 unit test: clock, reset, command stimulus, receiver stalls
// and the verdict; checking is done by cp0_result_checker
// depends on cp0_pkg, cp0_exception_interrupt_unit and cp0_result_checker
`timescale 1ns / 1ps

module testbench;
    import cp0_pkg::*;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int PHASES          = 4;
    localparam int HOLD_AFTER      = 150;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 4;

    // codes outside the defined sets
    localparam logic [3:0] CMD_LAST_CODE    = 4'd15;
    localparam logic [3:0] SEL_FIRST_UNUSED = 4'd13;
    localparam logic [3:0] SEL_LAST_CODE    = 4'd15;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  reg_select;
        logic [31:0] write_data;
        logic [4:0]  exc_code;
        logic [31:0] current_instr_addr;
        logic [31:0] resume_pc;
        logic        delay_slot;
    } cp0_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  command;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
    logic [4:0]  exc_code;
    logic [31:0] current_instr_addr;
    logic [31:0] resume_pc;
    logic        delay_slot;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic        redirect;
    logic [31:0] target_pc;
    logic        interrupt_taken;
    logic        halted;
    logic        error;
    int          fail_count;
    int          outstanding;

    int burst_left    = 0;
    int items_sent    = 0;
    int hold_requests = 0;

    cp0_exception_interrupt_unit DUT (.*);

    cp0_result_checker u_result_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ends the run when no item moves on either channel for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: stall pattern drawn anew at random, long hold on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int served;
        mode = 0;
        mode_left = 0;
        served = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (served < hold_requests)
            begin
                served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // offers one item in bursts with random gaps and waits until it is taken
    task automatic send_item(input cp0_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid           <= 1'b1;
        command            <= it.command;
        reg_select         <= it.reg_select;
        write_data         <= it.write_data;
        exc_code           <= it.exc_code;
        current_instr_addr <= it.current_instr_addr;
        resume_pc          <= it.resume_pc;
        delay_slot         <= it.delay_slot;
        do
            @(posedge clk);
        while (!in_ready);
        if (it.command <= CMD_WAIT)
            items_sent++;
    endtask

    task automatic issue(input logic [3:0] cmd, input logic [3:0] sel, input logic [31:0] wd,
                         input logic [4:0] code, input logic [31:0] iaddr,
                         input logic [31:0] rpc, input logic ds);
        send_item(cp0_item_t'{cmd, sel, wd, code, iaddr, rpc, ds});
    endtask

    function automatic cp0_item_t random_item(input logic [3:0] cmd);
        cp0_item_t it;
        it.command = cmd;
        if ($urandom_range(0, 7) == 0)
            it.reg_select = 4'($urandom);
        else
            it.reg_select = 4'($urandom_range(0, int'(SEL_L2REG)));
        it.write_data         = $urandom;
        it.exc_code           = 5'($urandom);
        it.current_instr_addr = $urandom;
        it.resume_pc          = $urandom;
        it.delay_slot         = 1'($urandom);
        return it;
    endfunction

    task automatic send_cmd(input logic [3:0] cmd);
        send_item(random_item(cmd));
    endtask

    task automatic send_with(input logic [3:0] cmd, input logic [3:0] sel, input logic [31:0] wd);
        cp0_item_t it;
        it = random_item(cmd);
        it.reg_select = sel;
        it.write_data = wd;
        send_item(it);
    endtask

    // status with exl clear and erl only now and then
    function automatic logic [31:0] random_status(input logic ie);
        logic [31:0] s;
        s = $urandom;
        s[ST_IE]  = ie;
        s[ST_EXL] = 1'b0;
        s[ST_ERL] = ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    // one short command sequence, mostly well formed
    task automatic run_sequence();
        int kind;
        int k;
        logic [3:0] sel;
        logic [31:0] v;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                // exception entry, a few reads, return
                if ($urandom_range(0, 1) == 1)
                    send_with(CMD_WRITE, SEL_STATUS, random_status(1'($urandom)));
                send_cmd(CMD_EXCEPTION);
                repeat ($urandom_range(0, 3)) send_cmd(CMD_READ);
                send_cmd(CMD_RETURN);
            end
            3, 4:
            begin
                // timer run up to compare, sometimes across the wrap
                v = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFE : $urandom;
                k = $urandom_range(1, 4);
                send_with(CMD_WRITE, SEL_COUNT, v);
                send_with(CMD_WRITE, SEL_COMPARE, v + 32'(k));
                repeat (k) send_cmd(CMD_TICK);
                send_with(CMD_READ, SEL_CAUSE, $urandom);
            end
            5, 6:
            begin
                // arm interrupts, raise one, drop the line, return
                send_with(CMD_WRITE, SEL_EBASE, $urandom);
                send_with(CMD_WRITE, SEL_STATUS, random_status($urandom_range(0, 3) != 0));
                case ($urandom_range(0, 4))
                    0:       send_cmd(CMD_IRQ_SET);
                    1:       send_cmd(CMD_SET_IE);
                    2:       send_cmd(CMD_WAIT);
                    3:       send_cmd(CMD_TICK);
                    default: send_with(CMD_WRITE, SEL_CAUSE, $urandom);
                endcase
                send_cmd(CMD_IRQ_CLEAR);
                send_cmd(CMD_RETURN);
            end
            7:
            begin
                // write then read back any register number
                sel = 4'($urandom);
                send_with(CMD_WRITE, sel, $urandom);
                send_with(CMD_READ, sel, $urandom);
            end
            8:
            begin
                send_cmd(4'($urandom_range(int'(CMD_READ), int'(CMD_WAIT))));
            end
            default:
            begin
                // noise: any command code at all
                send_cmd(4'($urandom));
            end
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_settings(input logic cpu, input logic [31:0] word);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CPU_NUMBER;
        cfg_data  <= {31'($urandom), cpu};
        @(posedge clk);
        cfg_index <= CFG_CONFIG_WORD;
        cfg_data  <= word;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        int phase_end;
        int hold_at;
        rst_n              <= 1'b0;
        cfg_write          <= 1'b0;
        cfg_index          <= CFG_CPU_NUMBER;
        cfg_data           <= '0;
        in_valid           <= 1'b0;
        command            <= CMD_READ;
        reg_select         <= SEL_COUNT;
        write_data         <= '0;
        exc_code           <= '0;
        current_instr_addr <= '0;
        resume_pc          <= '0;
        delay_slot         <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items on reset configuration
        issue(CMD_READ, SEL_CPUID, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_READ, SEL_LAST_CODE, '1, '1, '1, '1, 1'b1);
        issue(CMD_RETURN, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_EBASE, 32'hFFFF_FFFF, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_COMPARE, 32'd2, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_TICK, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_TICK, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_EXCEPTION, SEL_COUNT, 32'd0, 5'h1F, 32'hFFFF_FFFF, 32'd0, 1'b1);
        issue(CMD_EXCEPTION, SEL_COUNT, 32'd0, 5'h0A, 32'h0000_1000, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_STATUS, 32'h0000_FF03, 5'd0, 32'd0, 32'h0000_0040, 1'b0);
        // return straight into the pending timer interrupt
        issue(CMD_RETURN, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_STATUS, 32'h0000_FF06, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_RETURN, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_CONFIG, 32'h1234_5678, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_FIRST_UNUSED, 32'hFFFF_FFFF, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_SYSCALL, SEL_COUNT, 32'hFFFF_FFFF, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_READ, SEL_SCCODE, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_STATUS, 32'h0000_0400, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_IRQ_SET, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_IRQ_CLEAR, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WAIT, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'h0000_0100, 1'b0);
        // hardware line wakes the wait, epc taken back over the delay slot
        issue(CMD_IRQ_SET, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'h1234_5677, 1'b1);
        issue(CMD_SET_IE, SEL_COUNT, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_WRITE, SEL_CAUSE, 32'hFFFF_FFFF, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_LAST_CODE, SEL_LAST_CODE, '1, '1, '1, '1, 1'b1);
        issue(CMD_READ, SEL_L2REG, 32'd0, 5'd0, 32'd0, 32'd0, 1'b0);
        issue(CMD_READ, SEL_COUNT, 32'hFFFF_FFFF, 5'd0, 32'd0, 32'd0, 1'b0);

        // random phases, each on its own configuration
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0:       write_settings(1'b1, 32'hFFFF_FFFF);
                1:       write_settings(1'b0, 32'h0000_0000);
                2:       write_settings(1'b1, $urandom);
                default: write_settings(1'b0, $urandom);
            endcase
            phase_end = items_sent + ITEMS_PER_PHASE;
            hold_at = (phase % 2 == 0) ? items_sent + HOLD_AFTER : phase_end;
            while (items_sent < phase_end)
            begin
                // receiver holds off while the sender keeps offering items
                if (items_sent >= hold_at)
                begin
                    hold_requests++;
                    burst_left = LONG_HOLD;
                    hold_at = phase_end;
                end
                run_sequence();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cp0_pkg.sv
hdl/cp0_exception_interrupt_unit.sv
hdl/cp0_checker.sv
sim/cp0_result_checker.sv
sim/testbench.sv
